### rtl/core/s3ls_pkg.sv
// Package for the 3x3 linear system solver: shared types and constants.
package s3ls_pkg;

  // Number of unknowns, equations and divider lanes.
  localparam int unsigned NUM_LANES = 3;

  // Per-item status that travels beside the solution lanes.
  typedef struct packed {
    logic singular;
    logic det_sat;
  } s3ls_flags_t;

endpackage

### rtl/core/s3ls_in_if.sv
// Input channel: one item holding a 3x3 matrix and a right-hand vector.
interface s3ls_in_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] row1_col1;
  logic signed [DATA_WIDTH-1:0] row1_col2;
  logic signed [DATA_WIDTH-1:0] row1_col3;
  logic signed [DATA_WIDTH-1:0] row2_col1;
  logic signed [DATA_WIDTH-1:0] row2_col2;
  logic signed [DATA_WIDTH-1:0] row2_col3;
  logic signed [DATA_WIDTH-1:0] row3_col1;
  logic signed [DATA_WIDTH-1:0] row3_col2;
  logic signed [DATA_WIDTH-1:0] row3_col3;
  logic signed [DATA_WIDTH-1:0] rhs_first;
  logic signed [DATA_WIDTH-1:0] rhs_second;
  logic signed [DATA_WIDTH-1:0] rhs_third;

  modport source (
    output valid, row1_col1, row1_col2, row1_col3, row2_col1, row2_col2, row2_col3,
           row3_col1, row3_col2, row3_col3, rhs_first, rhs_second, rhs_third,
    input  ready
  );
  modport sink (
    input  valid, row1_col1, row1_col2, row1_col3, row2_col1, row2_col2, row2_col3,
           row3_col1, row3_col2, row3_col3, rhs_first, rhs_second, rhs_third,
    output ready
  );
endinterface

### rtl/core/s3ls_out_if.sv
// Result channel: solution vector, determinant and status flags.
interface s3ls_out_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sol_first;
  logic signed [DATA_WIDTH-1:0] sol_second;
  logic signed [DATA_WIDTH-1:0] sol_third;
  logic signed [DATA_WIDTH-1:0] determinant;
  logic                         singular;
  logic                         saturated;

  modport source (
    output valid, sol_first, sol_second, sol_third, determinant, singular, saturated,
    input  ready
  );
  modport sink (
    input  valid, sol_first, sol_second, sol_third, determinant, singular, saturated,
    output ready
  );
endinterface

### rtl/core/solve_3x3_linear_system.sv
// Top level: pipelined 3x3 linear system solver by Cramer's rule.
// An item passes stages A, B, C, D1, D2, E1 and E2, the divider and the output stage.
// Throughput: one item per cycle; the restoring divider has one register stage per
// quotient bit (DATA_WIDTH + 1 stages, three lanes), so it never holds an item back.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active low) clears every valid bit; data registers are not reset.
module solve_3x3_linear_system #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic   clk,
  input  logic   rst_n,
  s3ls_in_if.sink    in_s,
  s3ls_out_if.source out_s
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned L   = s3ls_pkg::NUM_LANES;
  localparam int unsigned PW  = 2 * W;       // product of two entries
  localparam int unsigned CW  = 2 * W + 1;   // cofactor
  localparam int unsigned HW  = 2 * W + 1;   // partial product of entry and cofactor half
  localparam int unsigned TW  = 3 * W + 1;   // entry times cofactor
  localparam int unsigned SW  = 3 * W + 3;   // sum of three terms
  localparam int unsigned MW  = SW;          // magnitude of a sum
  localparam int unsigned NM  = SW + F;      // shifted numerator magnitude
  localparam int unsigned QW  = W + 1;       // quotient bits produced
  localparam int unsigned NS  = QW + 8;      // total register stages

  // Global advance: the pipeline moves whenever the output register is free.
  logic en;
  logic [NS-1:0] vld_r;

  assign en         = out_s.ready || !vld_r[NS-1];
  assign in_s.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_s.valid};
    end
  end

  // Input fields gathered into a matrix and a vector.
  logic signed [W-1:0] a_in [3][3];
  logic signed [W-1:0] b_in [3];

  assign a_in[0][0] = in_s.row1_col1;
  assign a_in[0][1] = in_s.row1_col2;
  assign a_in[0][2] = in_s.row1_col3;
  assign a_in[1][0] = in_s.row2_col1;
  assign a_in[1][1] = in_s.row2_col2;
  assign a_in[1][2] = in_s.row2_col3;
  assign a_in[2][0] = in_s.row3_col1;
  assign a_in[2][1] = in_s.row3_col2;
  assign a_in[2][2] = in_s.row3_col3;
  assign b_in[0]    = in_s.rhs_first;
  assign b_in[1]    = in_s.rhs_second;
  assign b_in[2]    = in_s.rhs_third;

  // Stage A: the eighteen cofactor products.
  logic signed [PW-1:0] pa_r [3][3];
  logic signed [PW-1:0] pb_r [3][3];
  logic signed [W-1:0]  a0a_r [3];
  logic signed [W-1:0]  ba_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pa_r[i][j] <= a_in[(i+1)%3][(j+1)%3] * a_in[(i+2)%3][(j+2)%3];
          pb_r[i][j] <= a_in[(i+1)%3][(j+2)%3] * a_in[(i+2)%3][(j+1)%3];
        end
        a0a_r[i] <= a_in[0][i];
        ba_r[i]  <= b_in[i];
      end
    end
  end

  // Stage B: cofactors.
  logic signed [CW-1:0] c_r [3][3];
  logic signed [W-1:0]  a0b_r [3];
  logic signed [W-1:0]  bb_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          c_r[i][j] <= CW'(pa_r[i][j]) - CW'(pb_r[i][j]);
        end
        a0b_r[i] <= a0a_r[i];
        bb_r[i]  <= ba_r[i];
      end
    end
  end

  // Stage C: entry times cofactor, split into low and high half products.
  logic signed [HW-1:0] dlo_r [3];
  logic signed [HW-1:0] dhi_r [3];
  logic signed [HW-1:0] nlo_r [3][3];
  logic signed [HW-1:0] nhi_r [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        dlo_r[j] <= a0b_r[j] * $signed({1'b0, c_r[0][j][W-1:0]});
        dhi_r[j] <= a0b_r[j] * $signed(c_r[0][j][CW-1:W]);
        for (int i = 0; i < 3; i++) begin
          nlo_r[i][j] <= bb_r[j] * $signed({1'b0, c_r[j][i][W-1:0]});
          nhi_r[i][j] <= bb_r[j] * $signed(c_r[j][i][CW-1:W]);
        end
      end
    end
  end

  // Stage D1: recombine the half products into full terms.
  logic signed [TW-1:0] dt_r [3];
  logic signed [TW-1:0] nt_r [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        dt_r[j] <= (TW'(dhi_r[j]) <<< W) + TW'(dlo_r[j]);
        for (int i = 0; i < 3; i++) begin
          nt_r[i][j] <= (TW'(nhi_r[i][j]) <<< W) + TW'(nlo_r[i][j]);
        end
      end
    end
  end

  // Stage D2: determinant and the three numerators.
  logic signed [SW-1:0] det_r;
  logic signed [SW-1:0] num_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= SW'(dt_r[0]) + SW'(dt_r[1]) + SW'(dt_r[2]);
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= SW'(nt_r[i][0]) + SW'(nt_r[i][1]) + SW'(nt_r[i][2]);
      end
    end
  end

  // Stage E1: signs and magnitudes; numerators gain the fraction shift.
  logic          detneg_r;
  logic [MW-1:0] detmag_r;
  logic          numneg_r [3];
  logic [NM-1:0] numsh_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      detneg_r <= det_r[SW-1];
      detmag_r <= det_r[SW-1] ? MW'(-det_r) : MW'(det_r);
      for (int i = 0; i < 3; i++) begin
        numneg_r[i] <= num_r[i][SW-1];
        numsh_r[i]  <= (num_r[i][SW-1] ? NM'(MW'(-num_r[i])) : NM'(MW'(num_r[i]))) << F;
      end
    end
  end

  // Divider state; index 0 is stage E2, which seeds the lanes.
  logic [MW-1:0]           dv_mag_r  [QW+1];
  logic [W-1:0]            dv_det_r  [QW+1];
  s3ls_pkg::s3ls_flags_t   dv_flg_r  [QW+1];
  logic [MW-1:0]           dv_rem_r  [QW+1][L];
  logic [QW-1:0]           dv_low_r  [QW+1][L];
  logic [QW-1:0]           dv_q_r    [QW+1][L];
  logic                    dv_ov_r   [QW+1][L];
  logic                    dv_neg_r  [QW+1][L];

  // Stage E2: determinant output, overflow check and divider seed.
  logic [MW-1:0] dq;
  logic [MW-1:0] dlim;
  logic          dsat;
  logic [MW-1:0] dmag;

  always_comb begin
    dq   = detmag_r >> (2 * F);
    dlim = detneg_r ? (MW'(1) << (W - 1)) : ((MW'(1) << (W - 1)) - MW'(1));
    dsat = dq > dlim;
    dmag = dsat ? dlim : dq;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_mag_r[0]          <= detmag_r;
      dv_det_r[0]          <= detneg_r ? W'(-dmag) : W'(dmag);
      dv_flg_r[0].singular <= (detmag_r == '0);
      dv_flg_r[0].det_sat  <= dsat;
      for (int i = 0; i < L; i++) begin
        dv_ov_r[0][i]  <= NM'(numsh_r[i] >> QW) >= NM'(detmag_r);
        dv_rem_r[0][i] <= MW'(numsh_r[i] >> QW);
        dv_low_r[0][i] <= numsh_r[i][QW-1:0];
        dv_q_r[0][i]   <= '0;
        dv_neg_r[0][i] <= numneg_r[i] ^ detneg_r;
      end
    end
  end

  // Restoring divider: one quotient bit per stage in each lane.
  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [MW:0] trial [L];
    logic        ge    [L];

    always_comb begin
      for (int i = 0; i < L; i++) begin
        trial[i] = {dv_rem_r[k-1][i], dv_low_r[k-1][i][QW-1]};
        ge[i]    = trial[i] >= {1'b0, dv_mag_r[k-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_mag_r[k] <= dv_mag_r[k-1];
        dv_det_r[k] <= dv_det_r[k-1];
        dv_flg_r[k] <= dv_flg_r[k-1];
        for (int i = 0; i < L; i++) begin
          dv_rem_r[k][i] <= ge[i] ? MW'(trial[i] - {1'b0, dv_mag_r[k-1]}) : MW'(trial[i]);
          dv_low_r[k][i] <= dv_low_r[k-1][i] << 1;
          dv_q_r[k][i]   <= {dv_q_r[k-1][i][QW-2:0], ge[i]};
          dv_ov_r[k][i]  <= dv_ov_r[k-1][i];
          dv_neg_r[k][i] <= dv_neg_r[k-1][i];
        end
      end
    end
  end

  // Output stage: saturate each quotient, apply the sign, clear singular items.
  logic [QW-1:0] qlim [L];
  logic          qover [L];
  logic [QW-1:0] qmag [L];
  logic [W-1:0]  qval [L];
  logic          any_over;

  always_comb begin
    any_over = 1'b0;
    for (int i = 0; i < L; i++) begin
      qlim[i]  = dv_neg_r[QW][i] ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
      qover[i] = dv_ov_r[QW][i] || (dv_q_r[QW][i] > qlim[i]);
      qmag[i]  = qover[i] ? qlim[i] : dv_q_r[QW][i];
      qval[i]  = dv_neg_r[QW][i] ? W'(-qmag[i]) : W'(qmag[i]);
      any_over = any_over | qover[i];
    end
  end

  logic signed [W-1:0] sol_r [L];
  logic signed [W-1:0] det_out_r;
  logic                sing_r;
  logic                sat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < L; i++) begin
        sol_r[i] <= dv_flg_r[QW].singular ? '0 : qval[i];
      end
      det_out_r <= dv_flg_r[QW].singular ? '0 : dv_det_r[QW];
      sing_r    <= dv_flg_r[QW].singular;
      sat_r     <= !dv_flg_r[QW].singular && (dv_flg_r[QW].det_sat || any_over);
    end
  end

  assign out_s.valid       = vld_r[NS-1];
  assign out_s.sol_first   = sol_r[0];
  assign out_s.sol_second  = sol_r[1];
  assign out_s.sol_third   = sol_r[2];
  assign out_s.determinant = det_out_r;
  assign out_s.singular    = sing_r;
  assign out_s.saturated   = sat_r;

`ifndef SYNTH
  // A singular item carries zero outputs and no saturation.
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid && out_s.singular |-> out_s.sol_first == '0 && out_s.sol_second == '0 &&
      out_s.sol_third == '0 && out_s.determinant == '0 && !out_s.saturated)
    else $error("singular item with nonzero outputs");

  // The input side is held off exactly when a finished result is stalled.
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_s.ready == (out_s.ready || !out_s.valid))
    else $error("input ready disagrees with output stall");

  // After the last divider step the remainder lies below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS-2] && !dv_flg_r[QW].singular && !dv_ov_r[QW][0] |->
      dv_rem_r[QW][0] < dv_mag_r[QW])
    else $error("divider remainder out of range");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_s.valid)
    else $error("result valid straight after reset");
`endif

endmodule
